>>> rtl/rgbt_pkg.sv
// rgbt_pkg: shared types and constants for the range gcd block table
// no dependencies
package rgbt_pkg;

    localparam int DEPTH      = 1024;
    localparam int BLOCK_LEN  = 32;
    localparam int VALUE_BITS = 32;
    localparam int NBLOCKS    = (DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int IDX_W      = 10;
    localparam int BLK_W      = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int OFF_W      = $clog2(BLOCK_LEN);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int GCD_CNT_W  = $clog2(2 * VALUE_BITS + 2);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  first_index;
        logic [9:0]  last_index;
        logic [31:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] gcd_result;
        logic        range_error;
    } out_item_t;

    // classified job passed from front to back
    typedef struct packed {
        logic                  is_write;
        logic                  is_error;
        logic [IDX_W-1:0]      lo;
        logic [IDX_W-1:0]      hi;
        logic [VALUE_BITS-1:0] value;
    } job_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_GCD,
        ST_BLK_WR,
        ST_EMIT
    } bk_state_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_BLOCKS,
        PH_RIGHT
    } phase_t;

endpackage

>>> rtl/rgbt_ram.sv
// rgbt_ram: generic single write, single read RAM with registered read
// no dependencies
module rgbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH_W = 10
) (
    input  logic               clk,
    input  logic               we,
    input  logic [DEPTH_W-1:0] waddr,
    input  logic [WIDTH-1:0]   wdata,
    input  logic [DEPTH_W-1:0] raddr,
    output logic [WIDTH-1:0]   rdata
);

    logic [WIDTH-1:0] mem [2**DEPTH_W];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/rgbt_gcd.sv
// rgbt_gcd: iterative binary gcd, one shift or subtract step per cycle
// depends on rgbt_pkg
module rgbt_gcd
    import rgbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output logic                  done,
    output logic [VALUE_BITS-1:0] result
);

    logic [VALUE_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [GCD_CNT_W-1:0]  sh_reg, sh_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // binary gcd step: strip common twos, then subtract
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        sh_next   = sh_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = a;
            y_next    = b;
            sh_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg == '0)
            begin
                x_next    = y_reg;
                y_next    = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next  = x_reg >> 1;
                y_next  = y_reg >> 1;
                sh_next = sh_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        sh_reg <= sh_next;
    end

    assign done   = done_reg;
    assign result = x_reg << sh_reg;

endmodule

>>> rtl/rgbt_front.sv
// rgbt_front: accepts transactions, classifies them and queues jobs
// depends on rgbt_pkg
module rgbt_front
    import rgbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    output logic     job_valid,
    input  logic     job_take,
    output job_t     job
);

    job_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       acc, drop;
    job_t       cls;

    // classification of the incoming transaction
    always_comb
    begin
        cls.is_write = (in_item.cmd == CMD_WRITE);
        cls.is_error = (in_item.cmd == CMD_QUERY) &&
                       (in_item.first_index > in_item.last_index);
        cls.lo       = in_item.first_index;
        cls.hi       = in_item.last_index;
        cls.value    = in_item.new_value[VALUE_BITS-1:0];
        drop = cls.is_write && ({22'd0, in_item.first_index} >= DEPTH);
    end

    assign full = (cnt_reg == 2'd2);
    assign acc  = push && !full;
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rp_reg];

    // two-entry job queue
    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc && !drop)
        begin
            cnt_next = cnt_next + 2'd1;
        end
        if (job_take && job_valid)
        begin
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (acc && !drop)
            begin
                wp_reg <= !wp_reg;
            end
            if (job_take && job_valid)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !drop)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

>>> rtl/rgbt_back.sv
// rgbt_back: executes writes and range queries over the two stores
// depends on rgbt_pkg, rgbt_ram, rgbt_gcd
module rgbt_back
    import rgbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_take,
    input  job_t      job,
    output logic      res_valid,
    input  logic      res_take,
    output out_item_t res
);

    localparam int ELEM_AW = $clog2(DEPTH);

    bk_state_t             st_reg, st_next;
    phase_t                ph_reg, ph_next;
    job_t                  job_reg, job_rnext;
    logic [CNT_W-1:0]      pos_reg, pos_next, end_reg, end_next;
    logic [BLK_W:0]        bpos_reg, bpos_next, bend_reg, bend_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  rdsrc_reg, rdsrc_next, rdok_reg, rdok_next;
    logic                  rv_reg, rv_next;
    out_item_t             res_reg, res_rnext;
    logic [ELEM_AW-1:0]    clr_reg, clr_next;

    logic                  e_we, b_we, g_start, g_done, clearing;
    logic [ELEM_AW-1:0]    e_raddr, e_waddr;
    logic [BLK_W-1:0]      b_raddr, b_waddr;
    logic [VALUE_BITS-1:0] e_rdata, b_rdata, g_b, g_res, e_wdata, b_wdata;
    logic [IDX_W-1:0]      lo_blk, hi_blk;

    rgbt_ram #(.WIDTH(VALUE_BITS), .DEPTH_W(ELEM_AW)) u_elem (
        .clk(clk), .we(e_we), .waddr(e_waddr),
        .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));

    rgbt_ram #(.WIDTH(VALUE_BITS), .DEPTH_W(BLK_W)) u_blk (
        .clk(clk), .we(b_we), .waddr(b_waddr),
        .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));

    rgbt_gcd u_gcd (
        .clk(clk), .rst_n(rst_n), .start(g_start), .a(acc_reg), .b(g_b),
        .done(g_done), .result(g_res));

    // write ports zero both stores during the clearing pass
    assign clearing = (st_reg == ST_CLEAR);
    assign e_waddr  = clearing ? clr_reg : job_reg.lo[ELEM_AW-1:0];
    assign e_wdata  = clearing ? '0 : job_reg.value;
    assign b_waddr  = clearing ? clr_reg[BLK_W-1:0] : job_reg.lo[IDX_W-1:OFF_W];
    assign b_wdata  = clearing ? '0 : acc_reg;

    assign lo_blk   = job_reg.lo >> OFF_W;
    assign hi_blk   = job_reg.hi >> OFF_W;
    assign e_raddr  = pos_reg[ELEM_AW-1:0];
    assign b_raddr  = bpos_reg[BLK_W-1:0];
    assign res      = res_reg;
    assign res_valid = rv_reg;

    // sequencer: clear pass, writes, and queries walking left edge elements, block summaries, then right edge elements
    always_comb
    begin
        st_next    = st_reg;
        ph_next    = ph_reg;
        job_rnext  = job_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        bpos_next  = bpos_reg;
        bend_next  = bend_reg;
        acc_next   = acc_reg;
        rdsrc_next = rdsrc_reg;
        rdok_next  = rdok_reg;
        rv_next    = rv_reg;
        res_rnext  = res_reg;
        clr_next   = clr_reg;
        job_take   = 1'b0;
        e_we       = 1'b0;
        b_we       = 1'b0;
        g_start    = 1'b0;
        g_b        = rdok_reg ? (rdsrc_reg ? b_rdata : e_rdata) : '0;
        if (res_take && rv_reg)
        begin
            rv_next = 1'b0;
        end
        case (st_reg)
            ST_CLEAR:
            begin
                // zero one element and one summary per cycle after reset
                e_we     = 1'b1;
                b_we     = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ELEM_AW'(DEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take  = 1'b1;
                    job_rnext = job;
                    acc_next  = '0;
                    if (job.is_write)
                    begin
                        st_next = ST_WR;
                    end
                    else if (job.is_error)
                    begin
                        st_next = ST_EMIT;
                    end
                    else
                    begin
                        st_next  = ST_RD_ADDR;
                        ph_next  = PH_LEFT;
                        pos_next = CNT_W'(job.lo);
                        if ((job.lo >> OFF_W) == (job.hi >> OFF_W))
                        begin
                            end_next = CNT_W'(job.hi);
                        end
                        else
                        begin
                            end_next = CNT_W'((((job.lo >> OFF_W) + 1) << OFF_W) - 1);
                        end
                    end
                end
            end
            ST_WR:
            begin
                // store element, then rebuild its block
                e_we     = 1'b1;
                ph_next  = PH_RIGHT;
                pos_next = CNT_W'(lo_blk << OFF_W);
                if (((lo_blk + 1) << OFF_W) > DEPTH)
                begin
                    end_next = CNT_W'(DEPTH - 1);
                end
                else
                begin
                    end_next = CNT_W'(((lo_blk + 1) << OFF_W) - 1);
                end
                st_next = ST_RD_ADDR;
            end
            ST_RD_ADDR:
            begin
                rdsrc_next = (ph_reg == PH_BLOCKS);
                rdok_next  = (ph_reg == PH_BLOCKS) ? (bpos_reg < NBLOCKS)
                                                   : (pos_reg < DEPTH);
                st_next    = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                g_start = 1'b1;
                st_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (g_done)
                begin
                    acc_next = g_res;
                    st_next  = ST_RD_ADDR;
                    if (ph_reg == PH_BLOCKS)
                    begin
                        bpos_next = bpos_reg + 1'b1;
                        if (bpos_reg + 1'b1 >= bend_reg)
                        begin
                            ph_next  = PH_RIGHT;
                            pos_next = CNT_W'(hi_blk << OFF_W);
                            end_next = CNT_W'(job_reg.hi);
                        end
                    end
                    else if (pos_reg != end_reg)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    else if (ph_reg == PH_LEFT && lo_blk != hi_blk)
                    begin
                        if (lo_blk + 1 < hi_blk)
                        begin
                            ph_next   = PH_BLOCKS;
                            bpos_next = (BLK_W+1)'(lo_blk + 1);
                            bend_next = (BLK_W+1)'(hi_blk);
                        end
                        else
                        begin
                            ph_next  = PH_RIGHT;
                            pos_next = CNT_W'(hi_blk << OFF_W);
                            end_next = CNT_W'(job_reg.hi);
                        end
                    end
                    else
                    begin
                        st_next = job_reg.is_write ? ST_BLK_WR : ST_EMIT;
                    end
                end
            end
            ST_BLK_WR:
            begin
                b_we    = 1'b1;
                st_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!rv_reg || res_take)
                begin
                    rv_next                = 1'b1;
                    res_rnext.range_error  = job_reg.is_error;
                    res_rnext.gcd_result   = job_reg.is_error ? '0 : 32'(acc_reg);
                    st_next                = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLEAR;
            rv_reg  <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            rv_reg  <= rv_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg    <= ph_next;
        job_reg   <= job_rnext;
        pos_reg   <= pos_next;
        end_reg   <= end_next;
        bpos_reg  <= bpos_next;
        bend_reg  <= bend_next;
        acc_reg   <= acc_next;
        rdsrc_reg <= rdsrc_next;
        rdok_reg  <= rdok_next;
        res_reg   <= res_rnext;
    end

endmodule

>>> rtl/range_gcd_block_table.sv
// range gcd block table: element store plus per-block gcd summaries
// operand folds: each operand is read in ST_RD_ADDR and ST_RD_WAIT, then folded by the binary gcd unit;
// a write folds BLOCK_LEN elements, a query up to 2*BLOCK_LEN+NBLOCKS-2 operands,
// and a reversed range folds none and goes straight to the result
// throughput: one transaction at a time in the back end, front queue holds two
// reset: control cleared asynchronously, then a clearing pass zeroes both stores
module range_gcd_block_table
    import rgbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic job_valid, job_take, res_valid;
    job_t job;

    rgbt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .job_valid(job_valid), .job_take(job_take), .job(job));

    rgbt_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .res_valid(res_valid), .res_take(pop), .res(out_item));

    assign empty = !res_valid;

endmodule
